// ===== sv/cau_pkg.sv =====
// Package for the complex arithmetic unit: request types, codes and widths.
// Used by every module of the unit; it depends on nothing else.
`default_nettype none
package cau_pkg;

    // Number of fraction bits of the signed fixed-point operands.
    localparam int FRAC_BITS = 8;
    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;

    // Quotient bits kept by the divider cells; larger quotients saturate anyway.
    localparam int QUO_W     = 16;
    // Denominator is b_re^2 + b_im^2, which fits in 32 unsigned bits.
    localparam int DEN_W     = 32;
    // Partial remainder width: denominator shifted by all quotient bits.
    localparam int REM_W     = DEN_W + QUO_W;

    // Pipeline depth: three front stages, one cell per quotient bit, one output.
    localparam int FRONT_STG = 3;
    localparam int NSTG      = FRONT_STG + QUO_W + 1;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_NEG = 3'd4,
        MODE_CMP = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OVF = 2'd1,
        ST_DZ  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } in_req_t;

    typedef struct packed {
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic               equal;
        logic [1:0]         status;
    } out_req_t;

    // One quotient lane of the divider chain.
    typedef struct packed {
        logic             neg;
        logic             qovf;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] q;
    } lane_t;

    // Everything that travels down the cell chain with one request.
    typedef struct packed {
        lane_t              re;
        lane_t              im;
        logic [REM_W-1:0]   dsh;
        logic               is_div;
        logic               dz;
        logic signed [15:0] fix_re;
        logic signed [15:0] fix_im;
        logic               fix_ovf;
        logic               equal;
    } chain_t;

endpackage
`default_nettype wire

// ===== sv/cau_front.sv =====
// Front end of the complex arithmetic unit: products, sums and divider setup.
// Three register stages; depends on cau_pkg.
`default_nettype none
module cau_front
    import cau_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [FRONT_STG-1:0] en,
    input  wire logic                 in_valid,
    input  wire in_req_t              in_req,
    output logic [FRONT_STG-1:0]      vld,
    output chain_t                    dout
);

    // Stage A: the six products.
    logic               va_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_r_reg, p_bb_i_reg;
    in_req_t            ra_reg;

    // Stage B: sums of products and the simple results.
    logic               vb_reg;
    logic signed [32:0] mul_re_reg, mul_im_reg, n_re_reg, n_im_reg;
    logic [DEN_W-1:0]   den_reg;
    logic signed [16:0] simp_re_reg, simp_im_reg;
    logic [2:0]         mode_b_reg;
    logic               eq_b_reg;

    // Stage C: chain entry.
    logic               vc_reg;
    chain_t             c_reg;

    logic signed [16:0] simp_re_next, simp_im_next;
    logic signed [33:0] fix_re_w, fix_im_w;
    logic               ovf_re, ovf_im;
    logic signed [15:0] sat_re, sat_im;
    logic signed [32:0] abs_re, abs_im;
    logic [REM_W-1:0]   m_re, m_im, dlim;
    chain_t             c_next;

    function automatic logic signed [33:0] trunc_frac(input logic signed [32:0] x);
        logic signed [33:0] xe;
        logic signed [33:0] bias;
        xe   = {x[32], x};
        bias = x[32] ? 34'(FRAC_MASK) : 34'sd0;
        return (xe + bias) >>> FRAC_BITS;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
                va_reg <= in_valid;
            if (en[1])
                vb_reg <= va_reg;
            if (en[2])
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_rr_reg   <= in_req.a_re * in_req.b_re;
            p_ii_reg   <= in_req.a_im * in_req.b_im;
            p_ri_reg   <= in_req.a_re * in_req.b_im;
            p_ir_reg   <= in_req.a_im * in_req.b_re;
            p_bb_r_reg <= in_req.b_re * in_req.b_re;
            p_bb_i_reg <= in_req.b_im * in_req.b_im;
            ra_reg     <= in_req;
        end
        if (en[1])
        begin
            mul_re_reg  <= $signed({p_rr_reg[31], p_rr_reg}) - $signed({p_ii_reg[31], p_ii_reg});
            mul_im_reg  <= $signed({p_ri_reg[31], p_ri_reg}) + $signed({p_ir_reg[31], p_ir_reg});
            n_re_reg    <= $signed({p_rr_reg[31], p_rr_reg}) + $signed({p_ii_reg[31], p_ii_reg});
            n_im_reg    <= $signed({p_ir_reg[31], p_ir_reg}) - $signed({p_ri_reg[31], p_ri_reg});
            den_reg     <= DEN_W'(p_bb_r_reg) + DEN_W'(p_bb_i_reg);
            simp_re_reg <= simp_re_next;
            simp_im_reg <= simp_im_next;
            mode_b_reg  <= ra_reg.mode;
            eq_b_reg    <= (ra_reg.a_re == ra_reg.b_re) && (ra_reg.a_im == ra_reg.b_im);
        end
        if (en[2])
            c_reg <= c_next;
    end

    always_comb
    begin
        case (ra_reg.mode)
            MODE_ADD:
            begin
                simp_re_next = $signed({ra_reg.a_re[15], ra_reg.a_re})
                             + $signed({ra_reg.b_re[15], ra_reg.b_re});
                simp_im_next = $signed({ra_reg.a_im[15], ra_reg.a_im})
                             + $signed({ra_reg.b_im[15], ra_reg.b_im});
            end
            MODE_SUB:
            begin
                simp_re_next = $signed({ra_reg.a_re[15], ra_reg.a_re})
                             - $signed({ra_reg.b_re[15], ra_reg.b_re});
                simp_im_next = $signed({ra_reg.a_im[15], ra_reg.a_im})
                             - $signed({ra_reg.b_im[15], ra_reg.b_im});
            end
            MODE_NEG:
            begin
                simp_re_next = -$signed({ra_reg.a_re[15], ra_reg.a_re});
                simp_im_next = -$signed({ra_reg.a_im[15], ra_reg.a_im});
            end
            default:
            begin
                simp_re_next = 17'sd0;
                simp_im_next = 17'sd0;
            end
        endcase
    end

    always_comb
    begin
        if (mode_b_reg == MODE_MUL)
        begin
            fix_re_w = trunc_frac(mul_re_reg);
            fix_im_w = trunc_frac(mul_im_reg);
        end
        else
        begin
            fix_re_w = 34'(simp_re_reg);
            fix_im_w = 34'(simp_im_reg);
        end

        ovf_re = (fix_re_w > 34'sd32767) || (fix_re_w < -34'sd32768);
        ovf_im = (fix_im_w > 34'sd32767) || (fix_im_w < -34'sd32768);
        sat_re = ovf_re ? (fix_re_w[33] ? 16'sh8000 : 16'sh7fff) : fix_re_w[15:0];
        sat_im = ovf_im ? (fix_im_w[33] ? 16'sh8000 : 16'sh7fff) : fix_im_w[15:0];

        abs_re = n_re_reg[32] ? -n_re_reg : n_re_reg;
        abs_im = n_im_reg[32] ? -n_im_reg : n_im_reg;
        m_re   = REM_W'(abs_re[31:0]) << FRAC_BITS;
        m_im   = REM_W'(abs_im[31:0]) << FRAC_BITS;
        dlim   = REM_W'(den_reg) << QUO_W;

        c_next.re.neg  = n_re_reg[32];
        c_next.re.qovf = (m_re >= dlim);
        c_next.re.rem  = m_re;
        c_next.re.q    = '0;
        c_next.im.neg  = n_im_reg[32];
        c_next.im.qovf = (m_im >= dlim);
        c_next.im.rem  = m_im;
        c_next.im.q    = '0;
        c_next.dsh     = REM_W'(den_reg) << (QUO_W - 1);
        c_next.is_div  = (mode_b_reg == MODE_DIV);
        c_next.dz      = (den_reg == '0);
        c_next.fix_re  = sat_re;
        c_next.fix_im  = sat_im;
        c_next.fix_ovf = ovf_re || ovf_im;
        c_next.equal   = eq_b_reg;
    end

    assign vld  = {vc_reg, vb_reg, va_reg};
    assign dout = c_reg;

endmodule
`default_nettype wire

// ===== sv/cau_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit for both lanes.
// Depends on cau_pkg.
`default_nettype none
module cau_div_cell
    import cau_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   vin,
    input  wire chain_t din,
    output logic        vout,
    output chain_t      dout
);

    logic   v_reg;
    chain_t d_reg;
    chain_t d_next;
    logic   ge_re, ge_im;

    always_comb
    begin
        d_next = din;
        ge_re  = (din.re.rem >= din.dsh);
        ge_im  = (din.im.rem >= din.dsh);
        d_next.re.rem = ge_re ? din.re.rem - din.dsh : din.re.rem;
        d_next.im.rem = ge_im ? din.im.rem - din.dsh : din.im.rem;
        d_next.re.q   = {din.re.q[QUO_W-2:0], ge_re};
        d_next.im.q   = {din.im.q[QUO_W-2:0], ge_im};
        d_next.dsh    = din.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule
`default_nettype wire

// ===== sv/cau_finish.sv =====
// Output stage: applies quotient sign and saturation, picks status, holds the result.
// Depends on cau_pkg.
`default_nettype none
module cau_finish
    import cau_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   vin,
    input  wire chain_t din,
    output logic        out_valid,
    output out_req_t    out_req
);

    logic               v_reg;
    out_req_t           r_reg;
    out_req_t           r_next;
    logic signed [15:0] q_re, q_im;
    logic               s_re, s_im;

    // Signed 16-bit value of a quotient lane and whether it saturated.
    function automatic logic [16:0] lane_val(input lane_t l);
        logic        sat;
        logic [15:0] v;
        if (l.neg)
        begin
            sat = l.qovf || (l.q > 16'd32768);
            v   = sat ? 16'h8000 : 16'(-l.q);
        end
        else
        begin
            sat = l.qovf || l.q[15];
            v   = sat ? 16'h7fff : l.q;
        end
        return {sat, v};
    endfunction

    always_comb
    begin
        {s_re, q_re} = lane_val(din.re);
        {s_im, q_im} = lane_val(din.im);
        r_next.equal = din.equal;
        if (din.is_div)
        begin
            if (din.dz)
            begin
                r_next.res_re = 16'sd0;
                r_next.res_im = 16'sd0;
                r_next.status = ST_DZ;
            end
            else
            begin
                r_next.res_re = q_re;
                r_next.res_im = q_im;
                r_next.status = (s_re || s_im) ? ST_OVF : ST_OK;
            end
        end
        else
        begin
            r_next.res_re = din.fix_re;
            r_next.res_im = din.fix_im;
            r_next.status = din.fix_ovf ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            r_reg <= r_next;
    end

    assign out_valid = v_reg;
    assign out_req   = r_reg;

endmodule
`default_nettype wire

// ===== sv/complex_arith_unit_core.sv =====
// Complex arithmetic unit: add, subtract, multiply, divide, negate, compare.
// Every request passes 3 front stages, 16 divider cells and 1 output register;
// every mode takes the same path. Throughput: one request per cycle unless
// out_ready stalls the pipeline, set by the one-bit-per-cell divider chain.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
// Depends on cau_pkg, cau_front, cau_div_cell and cau_finish.
`default_nettype none
module complex_arith_unit_core
    import cau_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_req_t  in_req,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_req_t      out_req
);

    // Each stage holds a valid bit. A stage may load when it is empty or when
    // the stage after it loads at the same edge, so bubbles collapse and a request
    // can still enter while a finished result waits at the output, if any stage is empty.
    logic [NSTG-1:0] vld;
    logic [NSTG-1:0] adv;
    chain_t          link [QUO_W+1];

    assign adv[NSTG-1] = ~vld[NSTG-1] | out_ready;
    for (genvar i = 0; i < NSTG - 1; i++)
    begin : g_adv
        assign adv[i] = ~vld[i] | adv[i+1];
    end

    assign in_ready = adv[0];

    // Products, sums, non-divide results and divider setup.
    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv[FRONT_STG-1:0]),
        .in_valid (in_valid),
        .in_req   (in_req),
        .vld      (vld[FRONT_STG-1:0]),
        .dout     (link[0])
    );

    // Restoring division, most significant quotient bit first. Each cell
    // compares the partial remainder against the shifted denominator and hands
    // the remainder, the quotient so far and the halved denominator onward.
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv[FRONT_STG+i]),
            .vin   (vld[FRONT_STG+i-1]),
            .din   (link[i]),
            .vout  (vld[FRONT_STG+i]),
            .dout  (link[i+1])
        );
    end

    // Sign, saturation and status; the output register.
    cau_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv[NSTG-1]),
        .vin       (vld[NSTG-2]),
        .din       (link[QUO_W]),
        .out_valid (vld[NSTG-1]),
        .out_req   (out_req)
    );

    assign out_valid = vld[NSTG-1];

`ifndef SYNTH
    // A divide by zero always comes with a zero result.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_req.status == ST_DZ) |-> (out_req.res_re == 16'sd0)
            && (out_req.res_im == 16'sd0))
        else $error("divide by zero with nonzero result");

    // The status code is always one of the three defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_req.status == ST_OK) || (out_req.status == ST_OVF)
            || (out_req.status == ST_DZ))
        else $error("undefined status code");

    // Overflow means at least one part sits at a saturation limit.
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_req.status == ST_OVF) |->
            (out_req.res_re == 16'sh7fff) || (out_req.res_re == 16'sh8000)
            || (out_req.res_im == 16'sh7fff) || (out_req.res_im == 16'sh8000))
        else $error("overflow status without saturated part");

    // An empty first stage always takes a request.
    a_ready_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !vld[0] |-> in_ready)
        else $error("input stalled with an empty first stage");
`endif

endmodule
`default_nettype wire
